### src/dts_pkg.sv
// Shared types, codes and helper functions for the DSL token scanner.
`default_nettype none
package dts_pkg;

	localparam int OFFSET_WIDTH = 24;
	localparam int LINE_WIDTH   = 20;
	localparam int COLUMN_WIDTH = 16;
	localparam int QUEUE_DEPTH  = 8;
	localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_WIDTH   = QPTR_WIDTH + 1;

	localparam logic [3:0] K_EOF    = 4'd0;
	localparam logic [3:0] K_ERR    = 4'd1;
	localparam logic [3:0] K_IDENT  = 4'd2;
	localparam logic [3:0] K_STR    = 4'd3;
	localparam logic [3:0] K_INT    = 4'd4;
	localparam logic [3:0] K_FLOAT  = 4'd5;
	localparam logic [3:0] K_AT     = 4'd6;
	localparam logic [3:0] K_LPAREN = 4'd7;
	localparam logic [3:0] K_RPAREN = 4'd8;
	localparam logic [3:0] K_LBRACE = 4'd9;
	localparam logic [3:0] K_RBRACE = 4'd10;
	localparam logic [3:0] K_COLON  = 4'd11;
	localparam logic [3:0] K_COMMA  = 4'd12;
	localparam logic [3:0] K_MINUS  = 4'd13;

	localparam logic [1:0] E_NONE   = 2'd0;
	localparam logic [1:0] E_UNTERM = 2'd1;
	localparam logic [1:0] E_EXP    = 2'd2;
	localparam logic [1:0] E_UNEXP  = 2'd3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	localparam logic [63:0] MAG_CAP   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] LIMIT_LO  = 64'd922337203685477580;
	localparam logic [63:0] LIMIT_HI9 = 64'd922337203685477579;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]              token_kind;
		logic [1:0]              error_kind;
		logic [OFFSET_WIDTH-1:0] start_offset;
		logic [OFFSET_WIDTH-1:0] text_length;
		logic [LINE_WIDTH-1:0]   line_number;
		logic [COLUMN_WIDTH-1:0] column_number;
		logic signed [63:0]      int_value;
		logic                    last;
	} out_beat_t;

	typedef struct packed {
		logic [1:0]           count;
		out_beat_t [2:0]      rec;
	} wr_bundle_t;

	typedef struct packed {
		logic [OFFSET_WIDTH-1:0] off;
		logic [LINE_WIDTH-1:0]   line;
		logic [COLUMN_WIDTH-1:0] col;
	} pos_t;

	typedef struct packed {
		logic        ovf;
		logic [63:0] val;
	} acc_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
	endfunction

	function automatic pos_t step_pos(input pos_t p, input logic [7:0] c);
		pos_t q;
		q = p;
		q.off = p.off + OFFSET_WIDTH'(1);
		if (c == CH_NL) begin
			if (p.line != {LINE_WIDTH{1'b1}})
				q.line = p.line + LINE_WIDTH'(1);
			q.col = COLUMN_WIDTH'(1);
		end else if (p.col != {COLUMN_WIDTH{1'b1}}) begin
			q.col = p.col + COLUMN_WIDTH'(1);
		end
		return q;
	endfunction

	function automatic acc_t add_digit(input acc_t a, input logic [7:0] c);
		acc_t r;
		logic [3:0]  d;
		logic [63:0] lim;
		d = c[3:0];
		lim = (d == 4'd9) ? LIMIT_HI9 : LIMIT_LO;
		if (a.ovf || (a.val > lim)) begin
			r.ovf = 1'b1;
			r.val = MAG_CAP;
		end else begin
			r.ovf = 1'b0;
			r.val = {a.val[60:0], 3'b000} + {a.val[62:0], 1'b0} + 64'(d);
		end
		return r;
	endfunction

	function automatic logic [63:0] int_of(input logic [63:0] acc, input logic neg);
		if (neg)
			return (acc >= MAG_CAP) ? MAG_CAP : (~acc + 64'd1);
		return (acc >= MAG_CAP) ? (MAG_CAP - 64'd1) : acc;
	endfunction

	function automatic out_beat_t mk_rec(
		input logic [3:0]              kind,
		input logic [1:0]              err,
		input logic [OFFSET_WIDTH-1:0] off,
		input logic [OFFSET_WIDTH-1:0] len,
		input logic [LINE_WIDTH-1:0]   line,
		input logic [COLUMN_WIDTH-1:0] col,
		input logic [63:0]             val
	);
		out_beat_t r;
		r.token_kind    = kind;
		r.error_kind    = err;
		r.start_offset  = off;
		r.text_length   = len;
		r.line_number   = line;
		r.column_number = col;
		r.int_value     = val;
		r.last          = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

### src/dts_front.sv
// Scanner front end: classifies each byte and builds up to three result records.
`default_nettype none
module dts_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire dts_pkg::in_beat_t din,
	output dts_pkg::wr_bundle_t    bundle
);

	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_SLASH   = 4'd1;
	localparam logic [3:0] M_COMMENT = 4'd2;
	localparam logic [3:0] M_MINUS   = 4'd3;
	localparam logic [3:0] M_IDENT   = 4'd4;
	localparam logic [3:0] M_INT     = 4'd5;
	localparam logic [3:0] M_DOT     = 4'd6;
	localparam logic [3:0] M_FRAC    = 4'd7;
	localparam logic [3:0] M_EXP     = 4'd8;
	localparam logic [3:0] M_EXPSIGN = 4'd9;
	localparam logic [3:0] M_EXPDIG  = 4'd10;
	localparam logic [3:0] M_STR     = 4'd11;

	logic [3:0]         mode_q, mode_d;
	dts_pkg::pos_t      cur_q, cur_d, st_q, st_d;
	dts_pkg::acc_t      acc_q, acc_d;
	logic               neg_q, neg_d, esc_q, esc_d;

	always_comb begin
		logic [7:0]              c;
		logic                    rescan;
		logic [1:0]              n;
		logic [3:0]              kind;
		dts_pkg::out_beat_t [2:0] r;
		c = din.ch;
		mode_d = mode_q;
		cur_d = cur_q;
		st_d = st_q;
		acc_d = acc_q;
		neg_d = neg_q;
		esc_d = esc_q;
		rescan = 1'b0;
		n = 2'd0;
		kind = dts_pkg::K_AT;
		r = '0;
		if (din.is_end || (c == dts_pkg::CH_NUL)) begin
			case (mode_q)
				M_SLASH: begin
					r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_UNEXP, cur_q.off, '0,
						cur_q.line, cur_q.col, '0);
					n = n + 2'd1;
				end
				M_MINUS, M_IDENT, M_INT, M_FRAC, M_EXPDIG: begin
					kind = (mode_q == M_MINUS) ? dts_pkg::K_MINUS :
						(mode_q == M_IDENT) ? dts_pkg::K_IDENT :
						(mode_q == M_INT) ? dts_pkg::K_INT : dts_pkg::K_FLOAT;
					r[n] = dts_pkg::mk_rec(kind, dts_pkg::E_NONE, st_q.off, cur_q.off - st_q.off,
						st_q.line, st_q.col,
						(kind == dts_pkg::K_INT) ? dts_pkg::int_of(acc_q.val, neg_q) : '0);
					n = n + 2'd1;
				end
				M_DOT: begin
					r[n] = dts_pkg::mk_rec(dts_pkg::K_INT, dts_pkg::E_NONE, st_q.off,
						cur_q.off - st_q.off - dts_pkg::OFFSET_WIDTH'(1), st_q.line, st_q.col,
						dts_pkg::int_of(acc_q.val, neg_q));
					n = n + 2'd1;
					r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_UNEXP, cur_q.off, '0,
						cur_q.line, cur_q.col, '0);
					n = n + 2'd1;
				end
				M_EXP, M_EXPSIGN: begin
					r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_EXP, cur_q.off, '0,
						cur_q.line, cur_q.col, '0);
					n = n + 2'd1;
				end
				M_STR: begin
					r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_UNTERM, cur_q.off, '0,
						cur_q.line, cur_q.col, '0);
					n = n + 2'd1;
				end
				default: begin
				end
			endcase
			r[n] = dts_pkg::mk_rec(dts_pkg::K_EOF, dts_pkg::E_NONE, cur_q.off, '0,
				cur_q.line, cur_q.col, '0);
			n = n + 2'd1;
			mode_d = M_IDLE;
			cur_d = '{off: '0, line: dts_pkg::LINE_WIDTH'(1), col: dts_pkg::COLUMN_WIDTH'(1)};
			st_d = cur_d;
			acc_d = '0;
			neg_d = 1'b0;
			esc_d = 1'b0;
		end else begin
			case (mode_q)
				M_SLASH: begin
					if (c == dts_pkg::CH_SLASH) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_COMMENT;
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_UNEXP, cur_d.off, '0,
							cur_d.line, cur_d.col, '0);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_COMMENT: begin
					if (c != dts_pkg::CH_NL)
						cur_d = dts_pkg::step_pos(cur_d, c);
					else
						rescan = 1'b1;
				end
				M_MINUS: begin
					if (dts_pkg::is_digit(c)) begin
						acc_d = dts_pkg::add_digit(acc_d, c);
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_INT;
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_MINUS, dts_pkg::E_NONE, st_d.off,
							cur_d.off - st_d.off, st_d.line, st_d.col, '0);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_IDENT: begin
					if (dts_pkg::is_word(c)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_IDENT, dts_pkg::E_NONE, st_d.off,
							cur_d.off - st_d.off, st_d.line, st_d.col, '0);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_INT: begin
					if (dts_pkg::is_digit(c)) begin
						acc_d = dts_pkg::add_digit(acc_d, c);
						cur_d = dts_pkg::step_pos(cur_d, c);
					end else if (c == dts_pkg::CH_DOT) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_DOT;
					end else if ((c == dts_pkg::CH_LOWER_E) || (c == dts_pkg::CH_UPPER_E)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_EXP;
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_INT, dts_pkg::E_NONE, st_d.off,
							cur_d.off - st_d.off, st_d.line, st_d.col,
							dts_pkg::int_of(acc_d.val, neg_d));
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_DOT: begin
					if (dts_pkg::is_digit(c)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_FRAC;
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_INT, dts_pkg::E_NONE, st_d.off,
							cur_d.off - st_d.off - dts_pkg::OFFSET_WIDTH'(1), st_d.line, st_d.col,
							dts_pkg::int_of(acc_d.val, neg_d));
						n = n + 2'd1;
						r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_UNEXP, cur_d.off, '0,
							cur_d.line, cur_d.col, '0);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_FRAC: begin
					if (dts_pkg::is_digit(c)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
					end else if ((c == dts_pkg::CH_LOWER_E) || (c == dts_pkg::CH_UPPER_E)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_EXP;
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_FLOAT, dts_pkg::E_NONE, st_d.off,
							cur_d.off - st_d.off, st_d.line, st_d.col, '0);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_EXP: begin
					if ((c == dts_pkg::CH_PLUS) || (c == dts_pkg::CH_MINUS)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_EXPSIGN;
					end else if (dts_pkg::is_digit(c)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_EXPDIG;
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_EXP, cur_d.off, '0,
							cur_d.line, cur_d.col, '0);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_EXPSIGN: begin
					if (dts_pkg::is_digit(c)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
						mode_d = M_EXPDIG;
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_EXP, cur_d.off, '0,
							cur_d.line, cur_d.col, '0);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_EXPDIG: begin
					if (dts_pkg::is_digit(c)) begin
						cur_d = dts_pkg::step_pos(cur_d, c);
					end else begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_FLOAT, dts_pkg::E_NONE, st_d.off,
							cur_d.off - st_d.off, st_d.line, st_d.col, '0);
						n = n + 2'd1;
						rescan = 1'b1;
					end
				end
				M_STR: begin
					cur_d = dts_pkg::step_pos(cur_d, c);
					if (esc_d) begin
						esc_d = 1'b0;
					end else if (c == dts_pkg::CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (c == dts_pkg::CH_QUOTE) begin
						r[n] = dts_pkg::mk_rec(dts_pkg::K_STR, dts_pkg::E_NONE,
							st_d.off + dts_pkg::OFFSET_WIDTH'(1),
							cur_d.off - st_d.off - dts_pkg::OFFSET_WIDTH'(2),
							st_d.line, st_d.col, '0);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end
				end
				default: rescan = 1'b1;
			endcase
			if (rescan) begin
				mode_d = M_IDLE;
				if ((c == dts_pkg::CH_SPACE) || (c == dts_pkg::CH_TAB) ||
					(c == dts_pkg::CH_CR) || (c == dts_pkg::CH_NL)) begin
					cur_d = dts_pkg::step_pos(cur_d, c);
				end else if (c == dts_pkg::CH_HASH) begin
					cur_d = dts_pkg::step_pos(cur_d, c);
					mode_d = M_COMMENT;
				end else begin
					st_d = cur_d;
					cur_d = dts_pkg::step_pos(cur_d, c);
					if (c == dts_pkg::CH_SLASH) begin
						mode_d = M_SLASH;
					end else if (dts_pkg::is_alpha(c) || (c == dts_pkg::CH_UNDER)) begin
						mode_d = M_IDENT;
					end else if ((c == dts_pkg::CH_MINUS) || dts_pkg::is_digit(c)) begin
						neg_d = (c == dts_pkg::CH_MINUS);
						acc_d = '0;
						if (c == dts_pkg::CH_MINUS) begin
							mode_d = M_MINUS;
						end else begin
							acc_d = dts_pkg::add_digit('0, c);
							mode_d = M_INT;
						end
					end else if (c == dts_pkg::CH_QUOTE) begin
						esc_d = 1'b0;
						mode_d = M_STR;
					end else begin
						case (c)
							dts_pkg::CH_AT:     kind = dts_pkg::K_AT;
							dts_pkg::CH_LPAREN: kind = dts_pkg::K_LPAREN;
							dts_pkg::CH_RPAREN: kind = dts_pkg::K_RPAREN;
							dts_pkg::CH_LBRACE: kind = dts_pkg::K_LBRACE;
							dts_pkg::CH_RBRACE: kind = dts_pkg::K_RBRACE;
							dts_pkg::CH_COLON:  kind = dts_pkg::K_COLON;
							dts_pkg::CH_COMMA:  kind = dts_pkg::K_COMMA;
							default:            kind = dts_pkg::K_ERR;
						endcase
						if (kind == dts_pkg::K_ERR)
							r[n] = dts_pkg::mk_rec(dts_pkg::K_ERR, dts_pkg::E_UNEXP, cur_d.off,
								'0, cur_d.line, cur_d.col, '0);
						else
							r[n] = dts_pkg::mk_rec(kind, dts_pkg::E_NONE, st_d.off,
								cur_d.off - st_d.off, st_d.line, st_d.col, '0);
						n = n + 2'd1;
					end
				end
			end
		end
		if (n != 2'd0)
			r[n - 2'd1].last = 1'b1;
		bundle.count = take ? n : 2'd0;
		bundle.rec = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cur_q <= '{off: '0, line: dts_pkg::LINE_WIDTH'(1), col: dts_pkg::COLUMN_WIDTH'(1)};
			st_q <= '{off: '0, line: dts_pkg::LINE_WIDTH'(1), col: dts_pkg::COLUMN_WIDTH'(1)};
			acc_q <= '0;
			neg_q <= 1'b0;
			esc_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			cur_q <= cur_d;
			st_q <= st_d;
			acc_q <= acc_d;
			neg_q <= neg_d;
			esc_q <= esc_d;
		end
	end

endmodule
`default_nettype wire

### src/dts_queue.sv
// Result queue: takes up to three records a cycle, delivers one beat a cycle while pop is high.
`default_nettype none
module dts_queue (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire dts_pkg::wr_bundle_t             bundle,
	input  wire logic                            pop,
	output logic                                 full,
	output logic                                 empty,
	output dts_pkg::out_beat_t                   dout,
	output logic [dts_pkg::QCNT_WIDTH-1:0]       level
);

	dts_pkg::out_beat_t                 mem_q [dts_pkg::QUEUE_DEPTH];
	logic [dts_pkg::QPTR_WIDTH-1:0]     wp_q, rp_q;
	logic [dts_pkg::QCNT_WIDTH-1:0]     cnt_q;
	logic                               do_pop;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q > dts_pkg::QCNT_WIDTH'(dts_pkg::QUEUE_DEPTH - 3));
	assign do_pop = pop && !empty;
	assign dout   = mem_q[rp_q];
	assign level  = cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < bundle.count)
				mem_q[wp_q + dts_pkg::QPTR_WIDTH'(i)] <= bundle.rec[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + dts_pkg::QPTR_WIDTH'(bundle.count);
			if (do_pop)
				rp_q <= rp_q + dts_pkg::QPTR_WIDTH'(1);
			cnt_q <= cnt_q + dts_pkg::QCNT_WIDTH'(bundle.count)
				- dts_pkg::QCNT_WIDTH'(do_pop);
		end
	end

endmodule
`default_nettype wire

### src/dsl_token_scanner.sv
// Top level of the DSL token scanner: front end, result queue and checks.
//
//  channel  | handshake          | beat
//  ---------+--------------------+---------------------------
//  source   | push / full        | din  (ch, is_end)
//  tokens   | pop / empty        | dout (token record, last)
//
// One source byte per cycle while full is low; a byte yields zero to three tokens
// written to the eight-entry result queue in the same cycle it is taken.
// full rises when fewer than three queue entries are free, so input stalls
// only while the token side is behind.
// Tokens leave at one per cycle while pop is high; the first appears the cycle after its byte.
// Reset clears scanner state and queue pointers; no clearing pass.
`default_nettype none
module dsl_token_scanner (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire dts_pkg::in_beat_t  din,
	output logic                    empty,
	input  wire logic               pop,
	output dts_pkg::out_beat_t      dout
);

	dts_pkg::wr_bundle_t                bundle;
	logic [dts_pkg::QCNT_WIDTH-1:0]     level;
	logic                               take;

	assign take = push && !full;

	dts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.din    (din),
		.bundle (bundle)
	);

	dts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.bundle (bundle),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.dout   (dout),
		.level  (level)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= dts_pkg::QCNT_WIDTH'(dts_pkg::QUEUE_DEPTH))
		else $error("result queue overrun");

	a_end_gives_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (din.is_end || (din.ch == dts_pkg::CH_NUL))) |->
		(bundle.count != 2'd0) &&
		(bundle.rec[bundle.count - 2'd1].token_kind == dts_pkg::K_EOF))
		else $error("end of source without eof");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((dout.token_kind == dts_pkg::K_ERR) == (dout.error_kind != dts_pkg::E_NONE)))
		else $error("error code mismatch");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!take |-> (bundle.count == 2'd0))
		else $error("records written without an input beat");

endmodule
`default_nettype wire

### tb/sv/dsl_token_scanner_chk.sv
// Token scanner checker: watches both channels, predicts tokens and compares them.
module dsl_token_scanner_chk
	import dts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire logic      full,
	input  wire in_beat_t  din,
	input  wire logic      empty,
	input  wire logic      pop,
	input  wire out_beat_t dout,
	output int             fail_count,
	output int             pending_tokens
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		S_IDLE, S_SLASH, S_COMMENT, S_MINUS, S_IDENT, S_INT, S_DOT, S_FRAC,
		S_EXP, S_EXPSIGN, S_EXPDIG, S_STR
	} scan_state_t;

	localparam logic [OFFSET_WIDTH-1:0] OFF_ONE = 1;

	out_beat_t   token_fifo[$];
	out_beat_t   burst[$];
	scan_state_t mode;
	logic [OFFSET_WIDTH-1:0] cur_off, tok_off;
	logic [LINE_WIDTH-1:0]   cur_line, tok_line;
	logic [COLUMN_WIDTH-1:0] cur_col, tok_col;
	logic [63:0] mag;
	logic        neg, ovf, esc;

	function automatic out_beat_t tok_rec(logic [3:0] k, logic [1:0] e,
			logic [OFFSET_WIDTH-1:0] o, logic [OFFSET_WIDTH-1:0] l,
			logic [LINE_WIDTH-1:0] ln, logic [COLUMN_WIDTH-1:0] cl, logic [63:0] v);
		out_beat_t t;
		t.token_kind = k; t.error_kind = e; t.start_offset = o; t.text_length = l;
		t.line_number = ln; t.column_number = cl; t.int_value = v; t.last = 1'b0;
		return t;
	endfunction

	function automatic bit digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	task automatic clear_state();
		mode = S_IDLE; cur_off = '0; cur_line = 1; cur_col = 1;
		tok_off = '0; tok_line = 1; tok_col = 1; mag = '0;
		neg = 0; ovf = 0; esc = 0;
	endtask

	task automatic advance(logic [7:0] c);
		cur_off++;
		if (c == CH_NL) begin
			if (cur_line != '1) cur_line++;
			cur_col = 1;
		end else if (cur_col != '1) cur_col++;
	endtask

	task automatic emit_error(logic [1:0] e);
		burst.push_back(tok_rec(K_ERR, e, cur_off, '0, cur_line, cur_col, '0));
	endtask

	task automatic emit_token(logic [3:0] k, logic [OFFSET_WIDTH-1:0] trim);
		logic [63:0] v;
		v = '0;
		if (k == K_INT) begin
			if (neg) v = mag[63] ? 64'h8000_0000_0000_0000 : -mag;
			else v = mag[63] ? 64'h7fff_ffff_ffff_ffff : mag;
		end
		burst.push_back(tok_rec(k, E_NONE, tok_off, cur_off - tok_off - trim,
			tok_line, tok_col, v));
	endtask

	task automatic accumulate(logic [7:0] c);
		logic [63:0] d;
		d = 64'(c - "0");
		if (ovf || mag > (64'h8000_0000_0000_0000 - d) / 10) begin
			mag = 64'h8000_0000_0000_0000;
			ovf = 1;
		end else mag = mag * 10 + d;
	endtask

	task automatic scan_fresh(logic [7:0] c);
		logic [3:0] k;
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL) begin
			advance(c);
			return;
		end
		if (c == CH_HASH) begin
			advance(c); mode = S_COMMENT;
			return;
		end
		tok_off = cur_off; tok_line = cur_line; tok_col = cur_col;
		advance(c);
		if (c == CH_SLASH) mode = S_SLASH;
		else if (alpha(c) || c == CH_UNDER) mode = S_IDENT;
		else if (c == CH_MINUS || digit(c)) begin
			mag = '0; ovf = 0; neg = (c == CH_MINUS);
			if (neg) mode = S_MINUS;
			else begin
				accumulate(c); mode = S_INT;
			end
		end else if (c == CH_QUOTE) begin
			esc = 0; mode = S_STR;
		end else begin
			case (c)
				CH_AT:     k = K_AT;
				CH_LPAREN: k = K_LPAREN;
				CH_RPAREN: k = K_RPAREN;
				CH_LBRACE: k = K_LBRACE;
				CH_RBRACE: k = K_RBRACE;
				CH_COLON:  k = K_COLON;
				CH_COMMA:  k = K_COMMA;
				default:   k = K_ERR;
			endcase
			if (k == K_ERR) emit_error(E_UNEXP);
			else emit_token(k, '0);
		end
	endtask

	task automatic scan_byte(logic [7:0] c);
		bit rescan;
		bit e_char;
		rescan = 1;
		e_char = (c == CH_LOWER_E || c == CH_UPPER_E);
		case (mode)
			S_IDLE: begin
				scan_fresh(c); rescan = 0;
			end
			S_SLASH:
				if (c == CH_SLASH) begin
					advance(c); mode = S_COMMENT; rescan = 0;
				end else emit_error(E_UNEXP);
			S_COMMENT:
				if (c != CH_NL) begin
					advance(c); rescan = 0;
				end
			S_MINUS:
				if (digit(c)) begin
					accumulate(c); advance(c); mode = S_INT; rescan = 0;
				end else emit_token(K_MINUS, '0);
			S_IDENT:
				if (alpha(c) || digit(c) || c == CH_UNDER) begin
					advance(c); rescan = 0;
				end else emit_token(K_IDENT, '0);
			S_INT:
				if (digit(c)) begin
					accumulate(c); advance(c); rescan = 0;
				end else if (c == CH_DOT) begin
					advance(c); mode = S_DOT; rescan = 0;
				end else if (e_char) begin
					advance(c); mode = S_EXP; rescan = 0;
				end else emit_token(K_INT, '0);
			S_DOT:
				if (digit(c)) begin
					advance(c); mode = S_FRAC; rescan = 0;
				end else begin
					emit_token(K_INT, OFF_ONE); emit_error(E_UNEXP);
				end
			S_FRAC:
				if (digit(c)) begin
					advance(c); rescan = 0;
				end else if (e_char) begin
					advance(c); mode = S_EXP; rescan = 0;
				end else emit_token(K_FLOAT, '0);
			S_EXP:
				if (c == CH_PLUS || c == CH_MINUS) begin
					advance(c); mode = S_EXPSIGN; rescan = 0;
				end else if (digit(c)) begin
					advance(c); mode = S_EXPDIG; rescan = 0;
				end else emit_error(E_EXP);
			S_EXPSIGN:
				if (digit(c)) begin
					advance(c); mode = S_EXPDIG; rescan = 0;
				end else emit_error(E_EXP);
			S_EXPDIG:
				if (digit(c)) begin
					advance(c); rescan = 0;
				end else emit_token(K_FLOAT, '0);
			default: begin
				advance(c); rescan = 0;
				if (esc) esc = 0;
				else if (c == CH_BSLASH) esc = 1;
				else if (c == CH_QUOTE) begin
					burst.push_back(tok_rec(K_STR, E_NONE, tok_off + OFF_ONE,
						cur_off - tok_off - OFFSET_WIDTH'(2), tok_line, tok_col, '0));
					mode = S_IDLE;
				end
			end
		endcase
		if (rescan) begin
			mode = S_IDLE;
			scan_fresh(c);
		end
	endtask

	task automatic end_source();
		case (mode)
			S_SLASH: emit_error(E_UNEXP);
			S_MINUS: emit_token(K_MINUS, '0);
			S_IDENT: emit_token(K_IDENT, '0);
			S_INT:   emit_token(K_INT, '0);
			S_DOT: begin
				emit_token(K_INT, OFF_ONE); emit_error(E_UNEXP);
			end
			S_FRAC, S_EXPDIG: emit_token(K_FLOAT, '0);
			S_EXP, S_EXPSIGN: emit_error(E_EXP);
			S_STR: emit_error(E_UNTERM);
			default: ;
		endcase
		burst.push_back(tok_rec(K_EOF, E_NONE, cur_off, '0, cur_line, cur_col, '0));
		clear_state();
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: token mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending_tokens = 0;
		clear_state();
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && pop && !empty) begin
			if (token_fifo.size() == 0) begin
				report("unexpected beat, token_kind", dout.token_kind, '0);
			end else begin
				want = token_fifo.pop_front();
				if (dout.token_kind !== want.token_kind)
					report("token_kind", dout.token_kind, want.token_kind);
				if (dout.error_kind !== want.error_kind)
					report("error_kind", dout.error_kind, want.error_kind);
				if (dout.start_offset !== want.start_offset)
					report("start_offset", dout.start_offset, want.start_offset);
				if (dout.text_length !== want.text_length)
					report("text_length", dout.text_length, want.text_length);
				if (dout.line_number !== want.line_number)
					report("line_number", dout.line_number, want.line_number);
				if (dout.column_number !== want.column_number)
					report("column_number", dout.column_number, want.column_number);
				if (dout.int_value !== want.int_value)
					report("int_value", dout.int_value, want.int_value);
				if (dout.last !== want.last)
					report("last", dout.last, want.last);
			end
		end
		if (arst_n && push && !full) begin
			burst.delete();
			if (din.is_end || din.ch == CH_NUL) end_source();
			else scan_byte(din.ch);
			if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
			foreach (burst[i]) token_fifo.push_back(burst[i]);
		end
		pending_tokens = token_fifo.size();
	end
endmodule

### tb/sv/dsl_token_scanner_tb.sv
// Token scanner testbench top: clock, reset, source stimulus and verdict.
module dsl_token_scanner_tb;
	import dts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;

	logic      clk, arst_n, push, pop, full, empty;
	in_beat_t  din;
	out_beat_t dout;
	int        fail_count, pending_tokens;
	int        idle_cycles;
	int        sent;
	int        burst_left;
	bit        quiet;

	dsl_token_scanner dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(din),
		.empty(empty), .pop(pop), .dout(dout)
	);

	dsl_token_scanner_chk chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(din),
		.empty(empty), .pop(pop), .dout(dout), .fail_count(fail_count),
		.pending_tokens(pending_tokens)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: stall pattern of its own
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (quiet) pop <= 1'b1;
		else if ((($time / 1000) % 4) == 1) pop <= (r < 25);
		else pop <= (r < 80);
	end

	task automatic send_byte(logic [7:0] c, logic e);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		push <= 1'b1;
		din.ch <= c;
		din.is_end <= e;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_byte(s[i], 1'b0);
	endtask

	function automatic string random_lexeme();
		string s;
		int n;
		s = "";
		case ($urandom_range(0, 13))
			0: begin
				n = $urandom_range(1, 6);
				s = "x";
				repeat (n) s = {s, string'(8'($urandom_range(97, 122)))};
			end
			1: begin
				n = $urandom_range(1, 21);
				if ($urandom_range(0, 1)) s = "-";
				repeat (n) s = {s, string'(8'($urandom_range(48, 57)))};
			end
			2: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
			3: s = $sformatf("%0de%s%0d", $urandom_range(1, 9),
				$urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 30));
			4: s = "\"ab\\\"c d\"";
			5: s = "\"line\nnext\"";
			6: s = "@";
			7: s = "{";
			8: s = "}(,):";
			9: s = "# note\n";
			10: s = "// note\n";
			11: s = "1.x";
			12: s = "2e+q";
			default: s = string'(8'($urandom_range(1, 255)));
		endcase
		return {s, ($urandom_range(0, 2) == 0) ? "\n" : " "};
	endfunction

	initial begin
		string src;
		push = 0;
		din = '0;
		quiet = 0;
		idle_cycles = 0;
		sent = 0;
		burst_left = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_text("@(){}:,-x a_1 \"q\\\"\" 12 -9");
		send_byte(CH_NUL, 1'b0);
		send_text("9223372036854775808 -9223372036854775809 1.5e+3 1.a 3e/ /x 7.");
		send_byte(8'hff, 1'b1);
		send_text("\x80\xff\t\r\n\"open");
		send_byte(8'h00, 1'b1);

		quiet = 1;
		push <= 1'b0;
		while (pending_tokens != 0) @(negedge clk);
		quiet = 0;

		while (sent < 460) begin
			src = random_lexeme();
			send_text(src);
			if ($urandom_range(0, 40) == 0) send_byte(8'($urandom), 1'b1);
		end
		send_byte(CH_NUL, 1'b1);
		push <= 1'b0;
		while (pending_tokens != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule

### dsl_token_scanner.f
src/dts_pkg.sv
src/dts_front.sv
src/dts_queue.sv
src/dsl_token_scanner.sv
tb/sv/dsl_token_scanner_chk.sv
tb/sv/dsl_token_scanner_tb.sv
